// ----- rtl/keyframe_linear_sampler_unit_macros.svh -----
// -----------------------------------------------------------------
// Keyframe sampler assertion macros
// Shared concurrent assertion forms, clocked on clk, off in reset.
// -----------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_SAMPLER_UNIT_MACROS_SVH
`define KEYFRAME_LINEAR_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication
`define KLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/kls_pkg.sv -----
// -----------------------------------------------------------------
// Keyframe sampler package
// Sequencer states, command codes and fixed datapath widths.
// -----------------------------------------------------------------
package kls_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_CUR,
    ST_RD_NXT,
    ST_CAP_NXT,
    ST_SETUP,
    ST_DIV,
    ST_DLT,
    ST_ABS,
    ST_MUL,
    ST_ACC,
    ST_RND,
    ST_FIN,
    ST_DONE
  } state_t;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam int unsigned KIDX_W    = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned CHUNK_W   = 16;
  localparam int unsigned N_CHUNKS  = 3;
  localparam int unsigned N_COMP    = 3;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [34:0] MAG_LIM = 35'h4_0000_0000;

endpackage

// ----- rtl/keyframe_linear_sampler_unit.sv -----
// -----------------------------------------------------------------
// Keyframe linear sampler
// Holds up to MAX_KEYS timed 3-vector keys (Q16.16) in two on-chip
// RAMs and returns the vector linearly interpolated at a query time.
// Channels: cfg_* writes key_count; in_* takes items, in_tuser selects
// key write (0) or sample (1); out_* returns one item per sample.
// Key writes are taken only while idle and give no result. A sample scans the
// time RAM one key per cycle (read port bound), reads both bracketing
// keys, runs a 48-step restoring divide for the weight (skipped on a
// zero span) and a 32x16 multiply-accumulate, three chunks per axis.
// An empty table skips the scan and the arithmetic and returns the
// preset result with table_empty set.
// One sample is in flight at a time; the next item is taken as soon
// as the result sits in the output register, even if out_tready is
// low. A stalled receiver holds the result and, once a second result
// is ready, holds the sequencer in its final state.
// Reset (rst_n low, synchronous) clears key_count and the control
// state; RAM contents are undefined until written.
// -----------------------------------------------------------------
module keyframe_linear_sampler_unit #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // cfg_tdata: [6:0] key_count
  input  logic         cfg_tvalid,
  output logic         cfg_tready,
  input  logic [7:0]   cfg_tdata,
  // in_tdata: [5:0] key_index, [37:6] key_time, [69:38] key_x,
  //           [101:70] key_y, [133:102] key_z, [165:134] query_time
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,
  // in_tuser: [0] cmd
  input  logic         in_tuser,
  // out_tdata: [31:0] out_x, [63:32] out_y, [95:64] out_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,
  // out_tuser: [0] table_empty
  output logic         out_tuser
);

  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  // ---------------------------------------------------------------
  // input unpack
  // ---------------------------------------------------------------
  logic [kls_pkg::KIDX_W-1:0] in_key_index;
  logic [31:0]                in_key_time;
  logic [95:0]                in_key_xyz;
  logic [31:0]                in_query_time;

  assign in_key_index  = in_tdata[5:0];
  assign in_key_time   = in_tdata[37:6];
  assign in_key_xyz    = in_tdata[133:38];
  assign in_query_time = in_tdata[165:134];

  // ---------------------------------------------------------------
  // state
  // ---------------------------------------------------------------
  kls_pkg::state_t state_r, state_nxt;

  logic [kls_pkg::CNT_W-1:0] key_count_r;

  logic [31:0] t_mem [MAX_KEYS];
  logic [95:0] v_mem [MAX_KEYS];
  logic [31:0] t_rd_r;
  logic [95:0] v_rd_r;
  logic        mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic        mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [kls_pkg::KIDX_W+AW-1:0] wr_ext;

  logic [CW-1:0] n_r, n_now, issue_r, cmp_r;
  logic [31:0]   n_full;
  logic          pend_r;
  logic [31:0]   q_r;
  logic [AW-1:0] cur_r, nxt_r;

  logic [31:0] tc_r;
  logic [95:0] vc_r, vn_r;
  logic [32:0] d_r, span_r;
  logic [32:0] d_mag, span_mag;

  // divider: wq_r holds the dividend shifting out, quotient shifting in;
  // on a zero span it holds the raw time difference magnitude as the weight
  logic [47:0] wq_r;
  logic [31:0] rem_r, dvs_r;
  logic [5:0]  div_cnt_r;
  logic        wneg_r;
  logic [32:0] div_trial, div_diff;
  logic        div_ge;

  // lerp datapath
  logic [1:0]  comp_r, chunk_r;
  logic [31:0] a_r;
  logic [32:0] delta_r;
  logic [31:0] dmag_r;
  logic        neg_r;
  logic [47:0] pp_r;
  logic [79:0] acc_r;
  logic [34:0] mag_r;
  logic [35:0] rnd_m;
  logic        rnd_big;
  logic signed [36:0] fin_s;
  logic [31:0] fin_sat;
  logic [31:0] res_r [kls_pkg::N_COMP];
  logic        empty_r;

  // scan decode
  logic          scan_found, scan_last;
  logic [CW-1:0] cmp_m1, n_m1, cur_sel, cur_p1, nxt_sel;

  // output register
  logic        out_tvalid_r;
  logic [95:0] out_data_r;
  logic        out_empty_r;
  logic        out_load;

  logic        in_acc;

  assign cfg_tready = 1'b1;
  assign in_tready  = (state_r == kls_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_empty_r;
  assign out_load   = (state_r == kls_pkg::ST_DONE) && (!out_tvalid_r || out_tready);

  // effective key count, clamped to the table depth
  assign n_full = (32'(key_count_r) > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : 32'(key_count_r);
  assign n_now  = n_full[CW-1:0];

  // key writes land only while idle; no sample is in flight then, so the
  // read-modify path never sees a write to the entry it is using
  assign wr_ext      = {{AW{1'b0}}, in_key_index};
  assign mem_wr_addr = wr_ext[AW-1:0];
  assign mem_wr_en   = in_acc && (in_tuser == kls_pkg::CMD_WRITE) &&
                       (32'(in_key_index) < 32'(MAX_KEYS));

  // scan: first key later than the query, or the last key, ends it
  assign scan_found = pend_r && (t_rd_r > q_r);
  assign scan_last  = pend_r && (cmp_r == n_m1);
  assign cmp_m1     = cmp_r - CW'(1);
  assign n_m1       = n_r - CW'(1);
  assign cur_sel    = scan_found ? ((cmp_r == '0) ? '0 : cmp_m1) : n_m1;
  assign cur_p1     = cur_sel + CW'(1);
  assign nxt_sel    = (cur_p1 < n_r) ? cur_p1 : '0;

  // magnitudes of the signed differences
  assign d_mag    = d_r[32] ? (33'd0 - d_r) : d_r;
  assign span_mag = span_r[32] ? (33'd0 - span_r) : span_r;

  // one restoring divide step
  assign div_trial = {rem_r, wq_r[47]};
  assign div_diff  = div_trial - {1'b0, dvs_r};
  assign div_ge    = (div_trial >= {1'b0, dvs_r});

  // rounding: floor for negative products, clamp far out of range
  assign rnd_big = |acc_r[79:51];
  assign rnd_m   = {1'b0, acc_r[50:16]} + 36'(neg_r && (|acc_r[15:0]));

  assign fin_s = neg_r ? ($signed({{5{a_r[31]}}, a_r}) - $signed({2'b00, mag_r}))
                       : ($signed({{5{a_r[31]}}, a_r}) + $signed({2'b00, mag_r}));
  always_comb begin
    if (fin_s > 37'sd2147483647) begin
      fin_sat = 32'h7FFF_FFFF;
    end else if (fin_s < -37'sd2147483648) begin
      fin_sat = 32'h8000_0000;
    end else begin
      fin_sat = fin_s[31:0];
    end
  end

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kls_pkg::ST_IDLE;
      key_count_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_tvalid && cfg_tready) begin
        key_count_r <= cfg_tdata[6:0];
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = cur_r;
    unique case (state_r)
      kls_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser == kls_pkg::CMD_SAMPLE)) begin
          state_nxt = (n_now == '0) ? kls_pkg::ST_DONE : kls_pkg::ST_SCAN;
        end
      end
      kls_pkg::ST_SCAN: begin
        mem_rd_addr = issue_r[AW-1:0];
        if (scan_found || scan_last) begin
          state_nxt = kls_pkg::ST_RD_CUR;
        end else if (issue_r < n_r) begin
          mem_rd_en = 1'b1;
        end
      end
      kls_pkg::ST_RD_CUR: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cur_r;
        state_nxt   = kls_pkg::ST_RD_NXT;
      end
      kls_pkg::ST_RD_NXT: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = nxt_r;
        state_nxt   = kls_pkg::ST_CAP_NXT;
      end
      kls_pkg::ST_CAP_NXT: state_nxt = kls_pkg::ST_SETUP;
      kls_pkg::ST_SETUP: begin
        state_nxt = (span_r == '0) ? kls_pkg::ST_DLT : kls_pkg::ST_DIV;
      end
      kls_pkg::ST_DIV: begin
        if (div_cnt_r == 6'(kls_pkg::DIV_STEPS - 1)) begin
          state_nxt = kls_pkg::ST_DLT;
        end
      end
      kls_pkg::ST_DLT: state_nxt = kls_pkg::ST_ABS;
      kls_pkg::ST_ABS: state_nxt = kls_pkg::ST_MUL;
      kls_pkg::ST_MUL: state_nxt = kls_pkg::ST_ACC;
      kls_pkg::ST_ACC: begin
        state_nxt = (chunk_r == '0) ? kls_pkg::ST_RND : kls_pkg::ST_MUL;
      end
      kls_pkg::ST_RND: state_nxt = kls_pkg::ST_FIN;
      kls_pkg::ST_FIN: begin
        state_nxt = (comp_r == 2'(kls_pkg::N_COMP - 1)) ? kls_pkg::ST_DONE
                                                       : kls_pkg::ST_DLT;
      end
      kls_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = kls_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kls_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // key RAMs: one write port, one registered read port each
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      t_mem[mem_wr_addr] <= in_key_time;
      v_mem[mem_wr_addr] <= in_key_xyz;
    end
    if (mem_rd_en) begin
      t_rd_r <= t_mem[mem_rd_addr];
      v_rd_r <= v_mem[mem_rd_addr];
    end
  end

  // ---------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      kls_pkg::ST_IDLE: begin
        n_r     <= n_now;
        q_r     <= in_query_time;
        issue_r <= '0;
        pend_r  <= 1'b0;
        comp_r  <= '0;
        empty_r <= (n_now == '0);
        for (int i = 0; i < kls_pkg::N_COMP; i++) begin
          res_r[i] <= kls_pkg::ONE_Q16;
        end
      end
      kls_pkg::ST_SCAN: begin
        if (scan_found || scan_last) begin
          cur_r <= cur_sel[AW-1:0];
          nxt_r <= nxt_sel[AW-1:0];
        end else begin
          pend_r <= (issue_r < n_r);
          cmp_r  <= issue_r;
          if (issue_r < n_r) begin
            issue_r <= issue_r + CW'(1);
          end
        end
      end
      kls_pkg::ST_RD_NXT: begin
        tc_r <= t_rd_r;
        vc_r <= v_rd_r;
      end
      kls_pkg::ST_CAP_NXT: begin
        vn_r   <= v_rd_r;
        span_r <= {1'b0, t_rd_r} - {1'b0, tc_r};
        d_r    <= {1'b0, q_r} - {1'b0, tc_r};
      end
      kls_pkg::ST_SETUP: begin
        rem_r     <= '0;
        div_cnt_r <= '0;
        dvs_r     <= span_mag[31:0];
        if (span_r == '0) begin
          wq_r   <= {16'h0000, d_mag[31:0]};
          wneg_r <= d_r[32];
        end else begin
          wq_r   <= {d_mag[31:0], 16'h0000};
          wneg_r <= d_r[32] ^ span_r[32];
        end
      end
      kls_pkg::ST_DIV: begin
        rem_r     <= div_ge ? div_diff[31:0] : div_trial[31:0];
        wq_r      <= {wq_r[46:0], div_ge};
        div_cnt_r <= div_cnt_r + 6'd1;
      end
      kls_pkg::ST_DLT: begin
        a_r     <= vc_r[comp_r*32 +: 32];
        delta_r <= {vn_r[comp_r*32+31], vn_r[comp_r*32 +: 32]} -
                   {vc_r[comp_r*32+31], vc_r[comp_r*32 +: 32]};
      end
      kls_pkg::ST_ABS: begin
        dmag_r  <= delta_r[32] ? 32'(33'd0 - delta_r) : delta_r[31:0];
        neg_r   <= delta_r[32] ^ wneg_r;
        acc_r   <= '0;
        chunk_r <= 2'(kls_pkg::N_CHUNKS - 1);
      end
      kls_pkg::ST_MUL: begin
        pp_r <= 48'(dmag_r) * 48'(wq_r[chunk_r*kls_pkg::CHUNK_W +: kls_pkg::CHUNK_W]);
      end
      kls_pkg::ST_ACC: begin
        // high chunk first: shift what is there, add the new partial
        acc_r   <= {acc_r[63:0], 16'h0000} + 80'(pp_r);
        chunk_r <= chunk_r - 2'd1;
      end
      kls_pkg::ST_RND: begin
        mag_r <= (rnd_big || (rnd_m > 36'(kls_pkg::MAG_LIM))) ? kls_pkg::MAG_LIM
                                                               : rnd_m[34:0];
      end
      kls_pkg::ST_FIN: begin
        res_r[comp_r] <= fin_sat;
        comp_r        <= comp_r + 2'd1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_r  <= {res_r[2], res_r[1], res_r[0]};
      out_empty_r <= empty_r;
    end
  end

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  logic pair_ok;

  assign pair_ok = (CW'(cur_r) < n_r) && (CW'(nxt_r) < n_r);

`include "keyframe_linear_sampler_unit_macros.svh"

  `KLS_ASSERT_NOW(a_div_rem, state_r == kls_pkg::ST_DIV, rem_r < dvs_r, "div remainder high")
  `KLS_ASSERT_NOW(a_scan_idx, state_r == kls_pkg::ST_SCAN && pend_r, cmp_r < n_r, "scan overrun")
  `KLS_ASSERT_NOW(a_pair_idx, state_r == kls_pkg::ST_RD_CUR, pair_ok, "bracketing keys past count")
  `KLS_ASSERT_NEXT(a_result_out, out_load, out_tvalid_r, "finished sample not presented")

endmodule
